>>> src/aph_pkg.sv
// Shared types, widths and codes for the animation playhead timer.
package aph_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int REG_W = 32;
	localparam int IDX_W = 3;
	localparam int ELAPSED_W = 16;
	localparam int SPEED_W = 16;
	localparam int FRAC_BITS = 8;
	localparam int PROD_W = ELAPSED_W + SPEED_W + 1;
	localparam int DELTA_W = PROD_W - FRAC_BITS;
	localparam int POS_OUT_W = 32;
	localparam int MODE_W = 2;
	localparam int KIND_W = 2;
	localparam int OUT_W = 40;
	localparam int OUT_PAD = OUT_W - POS_OUT_W - MODE_W - 1;

	localparam logic [IDX_W-1:0] REG_LOOPED = 3'd0;
	localparam logic [IDX_W-1:0] REG_SPEED = 3'd1;
	localparam logic [IDX_W-1:0] REG_START = 3'd2;
	localparam logic [IDX_W-1:0] REG_STOP = 3'd3;
	localparam logic [IDX_W-1:0] REG_TOTAL = 3'd4;

	localparam logic signed [SPEED_W-1:0] SPEED_RESET = 16'sd256;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK,
		KIND_PLAY,
		KIND_PAUSE,
		KIND_STOP
	} kind_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_STOPPED,
		MODE_PLAYING,
		MODE_PAUSED
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_ADVANCE,
		ST_REDUCE,
		ST_APPLY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rem_stat_t;

endpackage

>>> src/aph_rem_unit.sv
// Iterative restoring remainder unit, one dividend bit per cycle.
module aph_rem_unit #(
	parameter int DVD_W = 34,
	parameter int DIV_W = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [DVD_W-1:0]        dividend,
	input  logic [DIV_W-1:0]        divisor,
	output logic [DIV_W-1:0]        rem,
	output aph_pkg::rem_stat_t      stat
);
	import aph_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);
	localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(DVD_W);

	logic [DVD_W-1:0] dvd_q;
	logic [DIV_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits = trial >= {1'b0, divisor};
	assign diff = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_INIT;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign rem = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < divisor))
		else $error("remainder not below divisor");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("remainder unit started while busy");

endmodule

>>> src/animation_playhead_timer.sv
// Top level: playback position counter with stopped, playing and paused modes.
// Sequence: a command or a tick that does not advance goes from ST_IDLE to ST_DONE; a tick that
// advances passes ST_SCALE and ST_ADVANCE, and one that wraps also passes ST_REDUCE, where it
// waits on the bit-serial remainder unit, and ST_APPLY. ST_DONE waits for the output register.
// Throughput: one item at a time; s_tready rises again once the result is in the output register.
// Reset: mode stopped, position zero, looped 0, speed 1.0 (256), time registers zero.
module animation_playhead_timer #(
	parameter int TIME_BITS = aph_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [aph_pkg::ELAPSED_W-1:0] s_tdata,   // [15:0] elapsed_ms
	input  logic [aph_pkg::KIND_W-1:0]    s_tuser,   // [1:0] kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [aph_pkg::OUT_W-1:0]     m_tdata,   // [31:0] position_ms, [33:32] play_state,
	                                                 // [34] refreshed, [39:35] zero
	input  logic                          wr_en,
	input  logic [aph_pkg::IDX_W-1:0]     wr_index,
	input  logic [aph_pkg::REG_W-1:0]     wr_data
);
	import aph_pkg::*;

	localparam int TW = (TIME_BITS < REG_W) ? TIME_BITS : REG_W;
	localparam int POS_W = ((TW > 31) ? TW : 31) + 3;
	localparam int DVD_W = POS_W - 1;

	state_t state_q, state_d;
	mode_t  mode_q;

	logic                        looped_q;
	logic signed [SPEED_W-1:0]   speed_q;
	logic [TW-1:0]               start_q;
	logic [TW-1:0]               stop_q;
	logic [TW-1:0]               total_q;
	logic signed [POS_W-1:0]     pos_q;
	logic signed [PROD_W-1:0]    prod_s1;
	logic                        refr_q;
	logic                        under_q;
	logic                        out_valid_q;
	logic [OUT_W-1:0]            out_data_q;

	logic [TW-1:0]               len_eff;
	logic signed [POS_W-1:0]     len_x;
	logic signed [POS_W-1:0]     start_x;
	logic signed [DELTA_W-1:0]   delta;
	logic                        round_up;
	logic                        over;
	logic                        under;
	logic signed [POS_W-1:0]     gap;
	logic [DVD_W-1:0]            dividend;
	logic [TW-1:0]               rem;
	logic signed [POS_W-1:0]     rem_x;
	rem_stat_t                   rem_stat;
	logic                        rem_start;
	logic                        accept;
	logic                        out_load;
	logic                        advances;
	logic [POS_OUT_W-1:0]        pos_sat;

	assign len_eff = (stop_q != '0 && stop_q < total_q) ? stop_q : total_q;
	assign len_x = $signed({{(POS_W-TW){1'b0}}, len_eff});
	assign start_x = $signed({{(POS_W-TW){1'b0}}, start_q});
	assign rem_x = $signed({{(POS_W-TW){1'b0}}, rem});

	assign round_up = prod_s1[PROD_W-1] & (|prod_s1[FRAC_BITS-1:0]);
	assign delta = $signed(prod_s1[PROD_W-1:FRAC_BITS])
		+ $signed({{(DELTA_W-1){1'b0}}, round_up});

	assign over = pos_q >= len_x;
	assign under = !over && (pos_q < start_x);
	assign gap = start_x - pos_q;
	assign dividend = over ? pos_q[DVD_W-1:0] : gap[DVD_W-1:0];

	assign advances = (kind_t'(s_tuser) == KIND_TICK) && (mode_q == MODE_PLAYING)
		&& (len_eff != '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = advances ? ST_SCALE : ST_DONE;
				end
			end
			ST_SCALE: state_d = ST_ADVANCE;
			ST_ADVANCE: begin
				state_d = (looped_q && (over || under)) ? ST_REDUCE : ST_DONE;
			end
			ST_REDUCE: begin
				if (rem_stat.done) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		rem_start = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_ADVANCE: rem_start = looped_q && (over || under);
			ST_DONE: out_load = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			looped_q <= 1'b0;
			speed_q <= SPEED_RESET;
			start_q <= '0;
			stop_q <= '0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				case (wr_index)
					REG_LOOPED: looped_q <= wr_data[0];
					REG_SPEED: speed_q <= $signed(wr_data[SPEED_W-1:0]);
					REG_START: start_q <= wr_data[TW-1:0];
					REG_STOP: stop_q <= wr_data[TW-1:0];
					REG_TOTAL: total_q <= wr_data[TW-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STOPPED;
			pos_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (kind_t'(s_tuser))
							KIND_PLAY: mode_q <= MODE_PLAYING;
							KIND_PAUSE: begin
								if (mode_q == MODE_PLAYING) begin
									mode_q <= MODE_PAUSED;
								end
							end
							KIND_STOP: begin
								if (mode_q != MODE_STOPPED) begin
									mode_q <= MODE_STOPPED;
									pos_q <= start_x;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCALE: begin
					pos_q <= pos_q + {{(POS_W-DELTA_W){delta[DELTA_W-1]}}, delta};
				end
				ST_ADVANCE: begin
					if (!looped_q && over) begin
						mode_q <= MODE_PAUSED;
						pos_q <= len_x;
					end else if (!looped_q && under) begin
						mode_q <= MODE_PAUSED;
						pos_q <= start_x;
					end
				end
				ST_APPLY: begin
					if (!under_q) begin
						pos_q <= start_x + rem_x;
					end else if (rem == '0) begin
						pos_q <= start_x;
					end else begin
						pos_q <= start_x + len_x - rem_x;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1 <= $signed({1'b0, s_tdata}) * speed_q;
			refr_q <= (kind_t'(s_tuser) == KIND_TICK) && (mode_q != MODE_STOPPED)
				&& (len_eff != '0);
		end
		if (state_q == ST_ADVANCE) begin
			under_q <= under;
		end
	end

	aph_rem_unit #(
		.DVD_W(DVD_W),
		.DIV_W(TW)
	) u_rem (
		.clk(clk),
		.arst_n(arst_n),
		.start(rem_start),
		.dividend(dividend),
		.divisor(len_eff),
		.rem(rem),
		.stat(rem_stat)
	);

	always_comb begin
		if (pos_q[POS_W-1]) begin
			pos_sat = '0;
		end else if (|pos_q[POS_W-2:POS_OUT_W]) begin
			pos_sat = '1;
		end else begin
			pos_sat = pos_q[POS_OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {{OUT_PAD{1'b0}}, refr_q, mode_q, pos_sat};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	a_reduce_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REDUCE) |-> (rem_stat.busy || rem_stat.done))
		else $error("waiting on an idle remainder unit");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second item taken while one is at work");
	a_refresh_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && refr_q) |-> (mode_q != MODE_STOPPED))
		else $error("refresh reported while stopped");

endmodule
